// File: rtl/sorted_two_list_merge_macros.svh
// Assertion macros shared by the sorted two-list merge RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SORTED_TWO_LIST_MERGE_MACROS_SVH
`define SORTED_TWO_LIST_MERGE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SMRG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMRG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/smrg_pkg.sv
// Package for the sorted two-list merge: command codes, queue item types, defaults.
// Depends on nothing; used by every module of the block.
package smrg_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int DATA_W        = 32;
  localparam int CMD_W         = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_MERGE         = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
  } queue_item_t;

  typedef struct packed {
    logic        push;
    queue_item_t item;
  } q_push_t;

  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } q_head_t;

endpackage

// File: rtl/smrg_front.sv
// Front end of the sorted two-list merge: accepts command transfers and classifies them.
// Depends on smrg_pkg; feeds smrg_queue.
module smrg_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [smrg_pkg::DATA_W-1:0] s_axis_tdata,  // value
  input  logic [smrg_pkg::CMD_W-1:0]  s_axis_tuser,  // cmd
  input  logic                        queue_full,
  output smrg_pkg::q_push_t           q_push
);
  import smrg_pkg::*;

  logic known_cmd;

  always_comb begin
    case (s_axis_tuser)
      CMD_APPEND_FIRST, CMD_APPEND_SECOND, CMD_MERGE: known_cmd = 1'b1;
      default:                                        known_cmd = 1'b0;
    endcase
  end

  // Unused command codes are taken and dropped here.
  assign s_axis_tready     = !queue_full;
  assign q_push.push       = s_axis_tvalid && !queue_full && known_cmd;
  assign q_push.item.cmd   = cmd_t'(s_axis_tuser);
  assign q_push.item.value = $signed(s_axis_tdata);

endmodule

// File: rtl/smrg_queue.sv
// Short command queue between the front end and the merge engine.
// Depends on smrg_pkg and sorted_two_list_merge_macros.svh.
module smrg_queue (
  input  logic              clk,
  input  logic              rst,
  input  smrg_pkg::q_push_t q_push,
  input  logic              pop,
  output logic              full,
  output smrg_pkg::q_head_t q_head
);
  import smrg_pkg::*;
  `include "sorted_two_list_merge_macros.svh"

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  queue_item_t          slots [QUEUE_DEPTH];
  logic [QAW-1:0]       wr_ptr;
  logic [QAW-1:0]       rd_ptr;
  logic [QCW-1:0]       count;
  logic                 do_pop;

  assign full         = (count == QCW'(QUEUE_DEPTH));
  assign q_head.valid = (count != '0);
  assign q_head.item  = slots[rd_ptr];
  assign do_pop       = pop && q_head.valid;

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots[wr_ptr] <= q_push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (q_push.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !q_push.push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SMRG_ASSERT_NOW(a_queue_no_overflow, clk, rst, q_push.push, !full || do_pop, "queue overflow")
  `SMRG_ASSERT_NEXT(a_queue_fill, clk, rst, q_push.push && !do_pop, count == $past(count) + 1'b1, "queue count did not rise")
  `SMRG_ASSERT_NEXT(a_queue_drain, clk, rst, do_pop && !q_push.push, count == $past(count) - 1'b1, "queue count did not fall")

endmodule

// File: rtl/smrg_engine.sv
// Merge engine: stores appended values in two memories and emits the merged run.
// Depends on smrg_pkg and sorted_two_list_merge_macros.svh; fed by smrg_queue.
module smrg_engine #(
  parameter int DEPTH = smrg_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  smrg_pkg::q_head_t           q_head,
  output logic                        pop,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [smrg_pkg::DATA_W-1:0] m_axis_tdata,  // merged_value
  output logic [0:0]                  m_axis_tuser,  // from_second
  output logic                        m_axis_tlast   // last
);
  import smrg_pkg::*;
  `include "sorted_two_list_merge_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = $clog2(2 * DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_PICK  = 3'b100
  } state_t;

  state_t                   state;
  logic signed [DATA_W-1:0] mem_first  [DEPTH];
  logic signed [DATA_W-1:0] mem_second [DEPTH];
  logic signed [DATA_W-1:0] rd_first;
  logic signed [DATA_W-1:0] rd_second;
  logic [CW-1:0]            cnt_first;
  logic [CW-1:0]            cnt_second;
  logic [CW-1:0]            idx_first;
  logic [CW-1:0]            idx_second;
  logic [RW-1:0]            remain;
  logic                     wr_first;
  logic                     wr_second;
  logic                     start_merge;
  logic                     have_first;
  logic                     have_second;
  logic                     take_first;
  logic                     out_free;
  logic                     pick;
  logic                     pick_last;

  assign pop = (state == S_IDLE) && q_head.valid;

  always_comb begin
    wr_first    = 1'b0;
    wr_second   = 1'b0;
    start_merge = 1'b0;
    if (pop) begin
      case (q_head.item.cmd)
        CMD_APPEND_FIRST:  wr_first    = (cnt_first < CW'(DEPTH));
        CMD_APPEND_SECOND: wr_second   = (cnt_second < CW'(DEPTH));
        CMD_MERGE:         start_merge = (cnt_first != '0) || (cnt_second != '0);
        default: begin
        end
      endcase
    end
  end

  assign have_first  = idx_first < cnt_first;
  assign have_second = idx_second < cnt_second;
  assign take_first  = have_first && (!have_second || (rd_first < rd_second));
  assign out_free    = !m_axis_tvalid || m_axis_tready;
  assign pick        = (state == S_PICK) && out_free;
  assign pick_last   = (remain == RW'(1));

  always_ff @(posedge clk) begin
    if (wr_first) begin
      mem_first[cnt_first[AW-1:0]] <= q_head.item.value;
    end
    if (wr_second) begin
      mem_second[cnt_second[AW-1:0]] <= q_head.item.value;
    end
    rd_first  <= mem_first[idx_first[AW-1:0]];
    rd_second <= mem_second[idx_second[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      m_axis_tdata    <= take_first ? rd_first : rd_second;
      m_axis_tuser[0] <= !take_first;
      m_axis_tlast    <= pick_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt_first     <= '0;
      cnt_second    <= '0;
      idx_first     <= '0;
      idx_second    <= '0;
      remain        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (pick) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (wr_first) begin
            cnt_first <= cnt_first + 1'b1;
          end
          if (wr_second) begin
            cnt_second <= cnt_second + 1'b1;
          end
          if (start_merge) begin
            idx_first  <= '0;
            idx_second <= '0;
            remain     <= RW'(cnt_first) + RW'(cnt_second);
            state      <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (pick) begin
            if (take_first) begin
              idx_first <= idx_first + 1'b1;
            end else begin
              idx_second <= idx_second + 1'b1;
            end
            remain <= remain - 1'b1;
            if (pick_last) begin
              cnt_first  <= '0;
              cnt_second <= '0;
              state      <= S_IDLE;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `SMRG_ASSERT_NOW(a_idx_first_bound, clk, rst, state != S_IDLE, idx_first <= cnt_first, "first index past its count")
  `SMRG_ASSERT_NOW(a_idx_second_bound, clk, rst, state != S_IDLE, idx_second <= cnt_second, "second index past its count")
  `SMRG_ASSERT_NOW(a_remain_match, clk, rst, state != S_IDLE, remain == RW'(cnt_first - idx_first) + RW'(cnt_second - idx_second), "remaining count out of step with indices")
  `SMRG_ASSERT_NOW(a_pick_has_data, clk, rst, pick, have_first || have_second, "result picked with both lists used up")
  `SMRG_ASSERT_NEXT(a_last_empties, clk, rst, pick && pick_last, cnt_first == '0 && cnt_second == '0 && state == S_IDLE, "stores not emptied after the last result")

endmodule

// File: rtl/sorted_two_list_merge.sv
// Top level of the sorted two-list merge: front end, command queue and merge engine.
// Depends on smrg_pkg, smrg_front, smrg_queue and smrg_engine.
//
// Append commands (tuser 0 or 1) load the tdata value into the first or second store, one
// transfer per cycle while the two-entry command queue has room; the merge engine takes each
// append while staying idle, and an append to a full store is dropped. A merge command
// (tuser 2) emits every stored value in ascending signed order, the second list winning ties,
// with tlast on the final result, then empties both stores. The engine reads both store
// memories through a registered port, so each merged result passes through a fetch state
// and then a pick state, where output stalls hold it. Command code 3 and a merge of two
// empty stores give no result.
module sorted_two_list_merge #(
  parameter int DEPTH = smrg_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [smrg_pkg::DATA_W-1:0] s_axis_tdata,  // value
  input  logic [smrg_pkg::CMD_W-1:0]  s_axis_tuser,  // cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [smrg_pkg::DATA_W-1:0] m_axis_tdata,  // merged_value
  output logic [0:0]                  m_axis_tuser,  // from_second
  output logic                        m_axis_tlast   // last
);
  import smrg_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    queue_full;
  logic    pop;

  smrg_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_full    (queue_full),
    .q_push        (q_push)
  );

  smrg_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .full   (queue_full),
    .q_head (q_head)
  );

  smrg_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .q_head        (q_head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for sorted_two_list_merge: streams append and merge commands,
// predicts the merged sequence of each merge and checks every result transfer in order.
// Depends on smrg_pkg and the sorted_two_list_merge RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import smrg_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEFAULT;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int STIM_TARGET = 100;
  localparam int HOLD_CYCLES = 250;
  localparam int HOLD_AFTER = 30;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [CMD_W-1:0]         code;
    logic signed [DATA_W-1:0] value;
  } command_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     from_second;
    logic                     last;
  } merged_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;
  logic [CMD_W-1:0]     s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic [0:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  command_t pending_cmds[$];
  merged_t  expected_merge[$];

  logic signed [DATA_W-1:0] first_vals [STORE_DEPTH];
  logic signed [DATA_W-1:0] second_vals [STORE_DEPTH];
  int first_cnt = 0;
  int second_cnt = 0;

  int stim_items = 0;
  int accepted_cnt = 0;
  int ignored_cnt = 0;
  int dropped_cnt = 0;
  int merge_runs = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   tx_gap = 0;
  bit   tx_calm = 1'b0;
  int   rx_wait = 0;
  bit   rx_calm = 1'b0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  sorted_two_list_merge u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 18));
  endfunction

  task automatic add_item(input logic [CMD_W-1:0] code, input logic signed [DATA_W-1:0] value);
    command_t c;
    c.code = code;
    c.value = value;
    pending_cmds.push_back(c);
    if (code != CMD_UNUSED) stim_items++;
  endtask

  task automatic add_run(input int n_first, input int n_second, input bit wide,
                         input bit sorted_order);
    logic signed [DATA_W-1:0] vals [2][40];
    logic signed [DATA_W-1:0] t;
    int cnt [2];
    int i, j, k, l;
    cnt[0] = n_first;
    cnt[1] = n_second;
    for (l = 0; l < 2; l++) begin
      for (i = 0; i < cnt[l]; i++) begin
        vals[l][i] = wide ? $urandom : ($urandom_range(0, 8) - 4);
      end
      if (sorted_order) begin
        for (i = 1; i < cnt[l]; i++) begin
          t = vals[l][i];
          k = i;
          while (k > 0 && vals[l][k-1] > t) begin
            vals[l][k] = vals[l][k-1];
            k--;
          end
          vals[l][k] = t;
        end
      end
    end
    i = 0;
    j = 0;
    while (i < cnt[0] || j < cnt[1]) begin
      if ($urandom_range(0, 9) == 0) add_item(CMD_UNUSED, $urandom);
      if (j >= cnt[1] || (i < cnt[0] && $urandom_range(0, 1) == 0)) begin
        add_item(CMD_APPEND_FIRST, vals[0][i]);
        i++;
      end else begin
        add_item(CMD_APPEND_SECOND, vals[1][j]);
        j++;
      end
    end
    add_item(CMD_MERGE, $urandom);
  endtask

  task automatic predict_merge();
    merged_t r;
    int a, b, total, n;
    a = 0;
    b = 0;
    n = 0;
    total = first_cnt + second_cnt;
    while (a < first_cnt || b < second_cnt) begin
      if (a < first_cnt && (b >= second_cnt || first_vals[a] < second_vals[b])) begin
        r.value = first_vals[a];
        r.from_second = 1'b0;
        a++;
      end else begin
        r.value = second_vals[b];
        r.from_second = 1'b1;
        b++;
      end
      n++;
      r.last = (n == total);
      expected_merge.push_back(r);
    end
    first_cnt = 0;
    second_cnt = 0;
    merge_runs++;
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] code,
                                 input logic signed [DATA_W-1:0] value);
    case (code)
      CMD_APPEND_FIRST: begin
        if (first_cnt < STORE_DEPTH) begin
          first_vals[first_cnt] = value;
          first_cnt++;
        end else begin
          dropped_cnt++;
        end
      end
      CMD_APPEND_SECOND: begin
        if (second_cnt < STORE_DEPTH) begin
          second_vals[second_cnt] = value;
          second_cnt++;
        end else begin
          dropped_cnt++;
        end
      end
      CMD_MERGE: predict_merge();
      default: ignored_cnt++;
    endcase
  endtask

  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      accepted_cnt++;
      predict_command(s_axis_tuser, s_axis_tdata);
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (tx_gap == 0 && pending_cmds.size() != 0) begin
        s_axis_tdata  <= pending_cmds[0].value;
        s_axis_tuser  <= pending_cmds[0].code;
        s_axis_tvalid <= 1'b1;
        void'(pending_cmds.pop_front());
        if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
        tx_gap = pick_gap(tx_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
        if (tx_gap != 0) tx_gap--;
      end
    end
  end

  // The long hold-off lets the sender keep offering transfers until the block stalls its input.
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && m_axis_tvalid && checked_cnt >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
        rx_wait = pick_gap(rx_calm);
      end
      if (rx_wait != 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_fire <= m_axis_tvalid && m_axis_tready && !rst;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_merge.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("Unexpected result transfer: value %0d from_second %0b last %0b",
                   $signed(m_axis_tdata), m_axis_tuser, m_axis_tlast);
      end else begin
        if (m_axis_tdata !== expected_merge[0].value ||
            m_axis_tuser[0] !== expected_merge[0].from_second ||
            m_axis_tlast !== expected_merge[0].last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display({"Mismatch on result %0d: expected value %0d from_second %0b last %0b,",
                      " got value %0d from_second %0b last %0b"},
                     checked_cnt, expected_merge[0].value, expected_merge[0].from_second,
                     expected_merge[0].last, $signed(m_axis_tdata), m_axis_tuser,
                     m_axis_tlast);
        end
        void'(expected_merge.pop_front());
        checked_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_cnt, expected_merge.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int run_idx;
    add_item(CMD_MERGE, 32'sd0);
    add_item(CMD_UNUSED, 32'shFFFF_FFFF);
    add_item(CMD_APPEND_FIRST, 32'sh8000_0000);
    add_item(CMD_APPEND_FIRST, 32'sd0);
    add_item(CMD_APPEND_FIRST, 32'sd5);
    add_item(CMD_APPEND_SECOND, 32'sh8000_0000);
    add_item(CMD_APPEND_SECOND, 32'sd5);
    add_item(CMD_APPEND_SECOND, 32'sh7FFF_FFFF);
    add_item(CMD_MERGE, 32'shFFFF_FFFF);
    add_item(CMD_APPEND_FIRST, -32'sd1);
    add_item(CMD_APPEND_FIRST, 32'sh7FFF_FFFF);
    add_item(CMD_MERGE, 32'sh5555_5555);
    add_item(CMD_APPEND_SECOND, -32'sd7);
    add_item(CMD_UNUSED, 32'sd123);
    add_item(CMD_APPEND_SECOND, -32'sd7);
    add_item(CMD_MERGE, 32'shAAAA_AAAA);
    add_item(CMD_APPEND_FIRST, 32'sd3);
    add_item(CMD_APPEND_FIRST, 32'sd1);
    add_item(CMD_APPEND_SECOND, 32'sd2);
    add_item(CMD_APPEND_SECOND, 32'sd2);
    add_item(CMD_MERGE, 32'sd0);
    run_idx = 0;
    while (stim_items < STIM_TARGET) begin
      if (run_idx == 2)
        add_run(STORE_DEPTH + 2, STORE_DEPTH + 1, 1'b1, 1'b1);
      else
        add_run($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 1),
                $urandom_range(0, 7) != 0);
      run_idx++;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_merge.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers in %0d merge runs, %0d ignored codes, %0d drops.",
             accepted_cnt, merge_runs, ignored_cnt, dropped_cnt);
    $display("Checked %0d merged results with %0d mismatches.", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0 && expected_merge.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/smrg_pkg.sv
rtl/smrg_front.sv
rtl/smrg_queue.sv
rtl/smrg_engine.sv
rtl/sorted_two_list_merge.sv
sim/testbench.sv
